>>> rtl/ps2d_pkg.sv
// Package for the PS/2 set-2 scancode decoder.
// Holds the prefix and modifier codes, the pause length and modifier bit indexes.
// No dependencies.
package ps2d_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] BYTE_RELEASE  = 8'hF0;
    localparam logic [BYTE_W-1:0] BYTE_EXTENDED = 8'hE0;
    localparam logic [BYTE_W-1:0] BYTE_PAUSE    = 8'hE1;
    localparam logic [BYTE_W-1:0] CODE_ALT      = 8'h11;
    localparam logic [BYTE_W-1:0] CODE_SHIFT_L  = 8'h12;
    localparam logic [BYTE_W-1:0] CODE_CTRL     = 8'h14;
    localparam logic [BYTE_W-1:0] CODE_SHIFT_R  = 8'h59;

    // E1 and the seven bytes after it form the pause sequence
    localparam int unsigned PAUSE_LENGTH = 8;
    localparam int unsigned PAUSE_CNT_W  = $clog2(PAUSE_LENGTH);

    localparam int unsigned MOD_COUNT = 7;
    localparam int unsigned MOD_IDX_W = $clog2(MOD_COUNT);

    localparam logic [MOD_IDX_W-1:0] MOD_LALT   = 3'd0;
    localparam logic [MOD_IDX_W-1:0] MOD_RALT   = 3'd1;
    localparam logic [MOD_IDX_W-1:0] MOD_LSHIFT = 3'd2;
    localparam logic [MOD_IDX_W-1:0] MOD_RSHIFT = 3'd3;
    localparam logic [MOD_IDX_W-1:0] MOD_LCTRL  = 3'd4;
    localparam logic [MOD_IDX_W-1:0] MOD_RCTRL  = 3'd5;
    localparam logic [MOD_IDX_W-1:0] MOD_PRTSCR = 3'd6;

    typedef logic [MOD_COUNT-1:0] t_mods;

endpackage

>>> rtl/ps2d_intf.sv
// Valid/ready channel interfaces for the PS/2 set-2 scancode decoder.
// Byte channel in, key event channel out. No dependencies.
interface ps2d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2d_event_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic       extended;
    logic       released;
    logic       left_alt_down;
    logic       right_alt_down;
    logic       left_shift_down;
    logic       right_shift_down;
    logic       left_ctrl_down;
    logic       right_ctrl_down;
    logic       prtscr_active;

    modport source (
        output valid, output key_code, output extended, output released,
        output left_alt_down, output right_alt_down, output left_shift_down,
        output right_shift_down, output left_ctrl_down, output right_ctrl_down,
        output prtscr_active, input ready
    );
    modport sink (
        input valid, input key_code, input extended, input released,
        input left_alt_down, input right_alt_down, input left_shift_down,
        input right_shift_down, input left_ctrl_down, input right_ctrl_down,
        input prtscr_active, output ready
    );
endinterface

>>> rtl/ps2_set2_scancode_decoder_unit.sv
// PS/2 scancode set 2 decoder, top level.
// Uses ps2d_pkg and the channel interfaces in ps2d_intf.sv.
//
// Takes one received keyboard byte per transfer on i_rx and produces at most
// one key event per byte on o_ev. F0 marks the next code as a release, E0 as
// extended; E1 opens the pause sequence, and that byte plus the seven that
// follow are consumed silently. Codes 11, 12, 14 and 59 update the seven
// modifier bits (alt, shift, ctrl on both sides and the print-screen marker)
// before the event is built, so the event reports the modifiers after this
// key. All other bytes, command responses included, come out as events with
// their raw code. A byte is latched in an input register, decoded, and the
// event is written to an output register; the sustained rate is one byte per
// clock while the sink takes events. The event is valid after the byte has
// passed the input and output registers. The input register keeps taking
// bytes while an event waits for the sink, and stalls only when a second
// event would have to pass one that has not been taken.
module ps2_set2_scancode_decoder_unit
    import ps2d_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ps2d_byte_if.sink            i_rx,
    ps2d_event_if.source         o_ev
);

    // Input register
    logic                   r_in_valid;
    logic [BYTE_W-1:0]      r_in_byte;

    // Decoder state
    logic                   r_rel;
    logic                   n_rel;
    logic                   r_ext;
    logic                   n_ext;
    logic [PAUSE_CNT_W-1:0] r_pause;
    logic [PAUSE_CNT_W-1:0] n_pause;
    t_mods                  r_mods;
    t_mods                  n_mods;

    // Output register
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [BYTE_W-1:0]      r_out_code;
    logic                   r_out_ext;
    logic                   r_out_rel;
    t_mods                  r_out_mods;

    logic                   emit;
    logic                   mod_hit;
    logic [MOD_IDX_W-1:0]   mod_sel;
    logic                   advance;
    logic                   in_ready;

    // Decode the held byte against the current state
    always_comb begin
        n_rel   = r_rel;
        n_ext   = r_ext;
        n_pause = r_pause;
        n_mods  = r_mods;
        emit    = 1'b0;
        mod_hit = 1'b0;
        mod_sel = MOD_LALT;

        if (r_pause != '0) begin
            // inside the pause sequence: advance the count only
            if (r_pause == PAUSE_CNT_W'(PAUSE_LENGTH - 1)) begin
                n_pause = '0;
            end else begin
                n_pause = r_pause + PAUSE_CNT_W'(1);
            end
        end else begin
            case (r_in_byte)
                BYTE_RELEASE: begin
                    n_rel = 1'b1;
                end
                BYTE_PAUSE: begin
                    n_pause = PAUSE_CNT_W'(1);
                end
                BYTE_EXTENDED: begin
                    n_ext = 1'b1;
                    n_rel = 1'b0;
                end
                default: begin
                    emit = 1'b1;
                    case (r_in_byte)
                        CODE_ALT: begin
                            mod_hit = 1'b1;
                            mod_sel = r_ext ? MOD_RALT : MOD_LALT;
                        end
                        CODE_SHIFT_L: begin
                            mod_hit = 1'b1;
                            mod_sel = r_ext ? MOD_PRTSCR : MOD_LSHIFT;
                        end
                        CODE_CTRL: begin
                            mod_hit = 1'b1;
                            mod_sel = r_ext ? MOD_RCTRL : MOD_LCTRL;
                        end
                        CODE_SHIFT_R: begin
                            mod_hit = 1'b1;
                            mod_sel = MOD_RSHIFT;
                        end
                        default: begin
                            mod_hit = 1'b0;
                        end
                    endcase
                    // press sets the modifier, release drops it
                    if (mod_hit) begin
                        n_mods[mod_sel] = ~r_rel;
                    end
                    n_rel = 1'b0;
                    n_ext = 1'b0;
                end
            endcase
        end
    end

    // Hold the byte while its event cannot enter a full output register
    assign advance  = r_in_valid && (!emit || !r_out_valid || o_ev.ready);
    assign in_ready = !r_in_valid || advance;

    always_comb begin
        if (advance && emit) begin
            n_out_valid = 1'b1;
        end else if (o_ev.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rel       <= 1'b0;
            r_ext       <= 1'b0;
            r_pause     <= '0;
            r_mods      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (advance) begin
                r_rel   <= n_rel;
                r_ext   <= n_ext;
                r_pause <= n_pause;
                r_mods  <= n_mods;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (advance && emit) begin
            r_out_code <= r_in_byte;
            r_out_ext  <= r_ext;
            r_out_rel  <= r_rel;
            r_out_mods <= n_mods;
        end
    end

    assign i_rx.ready = in_ready;

    assign o_ev.valid            = r_out_valid;
    assign o_ev.key_code         = r_out_code;
    assign o_ev.extended         = r_out_ext;
    assign o_ev.released         = r_out_rel;
    assign o_ev.left_alt_down    = r_out_mods[MOD_LALT];
    assign o_ev.right_alt_down   = r_out_mods[MOD_RALT];
    assign o_ev.left_shift_down  = r_out_mods[MOD_LSHIFT];
    assign o_ev.right_shift_down = r_out_mods[MOD_RSHIFT];
    assign o_ev.left_ctrl_down   = r_out_mods[MOD_LCTRL];
    assign o_ev.right_ctrl_down  = r_out_mods[MOD_RCTRL];
    assign o_ev.prtscr_active    = r_out_mods[MOD_PRTSCR];

endmodule

>>> sim/ps2_set2_scancode_decoder_unit_tb.sv
// Testbench for ps2_set2_scancode_decoder_unit: drives keyboard bytes and checks key events.
// It predicts each event from its own decoder state and compares it field by field.
// Depends on ps2d_pkg, ps2d_intf.sv and the decoder top level.
module ps2_set2_scancode_decoder_unit_tb;
    import ps2d_pkg::*;

    localparam int unsigned CLK_HALF          = 6;
    localparam int unsigned RESET_CYCLES      = 9;
    localparam int unsigned LONG_STALL_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES      = 8;
    localparam int unsigned TIMEOUT_CYCLES    = 400000;

    // Opening traffic: field extremes, every modifier code with and without E0,
    // E0 clearing a pending release, a repeated F0, and a pause sequence that
    // swallows prefixes while the release flag survives it.
    localparam int unsigned OPENING_LEN = 29;
    localparam logic [BYTE_W-1:0] OPENING_BYTES [OPENING_LEN] = '{
        8'h00, 8'hFF, CODE_ALT, CODE_SHIFT_L, CODE_CTRL, CODE_SHIFT_R,
        BYTE_EXTENDED, CODE_ALT,
        BYTE_EXTENDED, CODE_SHIFT_L,
        BYTE_EXTENDED, CODE_CTRL,
        BYTE_EXTENDED, BYTE_RELEASE, CODE_SHIFT_L,
        BYTE_RELEASE, BYTE_EXTENDED, CODE_SHIFT_R,
        BYTE_RELEASE, BYTE_RELEASE, BYTE_PAUSE,
        BYTE_RELEASE, BYTE_EXTENDED, BYTE_PAUSE, 8'h00, 8'hFF, CODE_SHIFT_L, CODE_CTRL,
        CODE_ALT
    };

    // One key event as the decoder reports it
    typedef struct packed {
        logic [BYTE_W-1:0] key_code;
        logic              extended;
        logic              released;
        t_mods             mods;
    } t_key_event;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ps2d_byte_if  byte_ch ();
    ps2d_event_if event_ch ();

    ps2_set2_scancode_decoder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (byte_ch),
        .o_ev    (event_ch)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Bytes waiting for the driver, events waiting for the decoder
    logic [BYTE_W-1:0] pending_bytes[$];
    t_key_event        expected_events[$];
    int unsigned       error_count = 0;

    // Idle control, set per phase by the stimulus process and the long-stall process
    logic send_gaps_on = 1'b1;
    logic recv_gaps_on = 1'b1;
    logic sink_hold    = 1'b0;
    event begin_sink_stall;

    // Shadow decoder state
    logic                   release_seen;
    logic                   extended_seen;
    logic [PAUSE_CNT_W-1:0] pause_pos;
    t_mods                  held_modifiers;

    string mod_names [MOD_COUNT] = '{
        "left_alt_down", "right_alt_down", "left_shift_down", "right_shift_down",
        "left_ctrl_down", "right_ctrl_down", "prtscr_active"
    };

    // Mostly back-to-back, sometimes a few cycles, rarely a long gap
    function automatic int unsigned draw_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void clear_decoder_state();
        release_seen   = 1'b0;
        extended_seen  = 1'b0;
        pause_pos      = '0;
        held_modifiers = '0;
    endfunction

    // Advance the shadow decoder by one accepted byte; queue the event it yields
    function automatic void predict_key_event(input logic [BYTE_W-1:0] rx);
        t_key_event ev;
        logic       down;
        // inside a pause every byte only moves the counter, flags stay
        if (pause_pos != '0) begin
            if (pause_pos == PAUSE_CNT_W'(PAUSE_LENGTH - 1)) pause_pos = '0;
            else pause_pos = pause_pos + PAUSE_CNT_W'(1);
            return;
        end
        case (rx)
            BYTE_RELEASE: begin
                release_seen = 1'b1;
                return;
            end
            BYTE_PAUSE: begin
                pause_pos = PAUSE_CNT_W'(1);
                return;
            end
            BYTE_EXTENDED: begin
                extended_seen = 1'b1;
                release_seen  = 1'b0;
                return;
            end
            default: ;
        endcase
        down = !release_seen;
        case (rx)
            CODE_ALT:     held_modifiers[extended_seen ? MOD_RALT : MOD_LALT] = down;
            CODE_SHIFT_L: held_modifiers[extended_seen ? MOD_PRTSCR : MOD_LSHIFT] = down;
            CODE_CTRL:    held_modifiers[extended_seen ? MOD_RCTRL : MOD_LCTRL] = down;
            CODE_SHIFT_R: held_modifiers[MOD_RSHIFT] = down;
            default: ;
        endcase
        ev.key_code = rx;
        ev.extended = extended_seen;
        ev.released = release_seen;
        ev.mods     = held_modifiers;
        expected_events.push_back(ev);
        extended_seen = 1'b0;
        release_seen  = 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Driver: present the next pending byte, advance on each transfer and
    // feed every transferred byte to the predictor.
    int unsigned send_wait = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid   <= 1'b0;
            byte_ch.rx_byte <= '0;
            send_wait       <= 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                predict_key_event(byte_ch.rx_byte);
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (send_wait != 0) begin
                    byte_ch.valid <= 1'b0;
                    send_wait     <= send_wait - 1;
                end else if (pending_bytes.size() != 0) begin
                    byte_ch.valid   <= 1'b1;
                    byte_ch.rx_byte <= pending_bytes.pop_front();
                    send_wait       <= send_gaps_on ? draw_gap() : 0;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: on each event transfer compare against the oldest expectation,
    // and drive ready, with random gaps when they are enabled, unless the long stall holds it low.
    int unsigned recv_wait = 0;

    always @(posedge i_clk) begin
        t_key_event want;
        t_key_event got;
        if (!i_rst_n) begin
            event_ch.ready <= 1'b0;
            recv_wait      <= 0;
        end else begin
            if (event_ch.valid && event_ch.ready) begin
                got.key_code            = event_ch.key_code;
                got.extended            = event_ch.extended;
                got.released            = event_ch.released;
                got.mods[MOD_LALT]      = event_ch.left_alt_down;
                got.mods[MOD_RALT]      = event_ch.right_alt_down;
                got.mods[MOD_LSHIFT]    = event_ch.left_shift_down;
                got.mods[MOD_RSHIFT]    = event_ch.right_shift_down;
                got.mods[MOD_LCTRL]     = event_ch.left_ctrl_down;
                got.mods[MOD_RCTRL]     = event_ch.right_ctrl_down;
                got.mods[MOD_PRTSCR]    = event_ch.prtscr_active;
                if (expected_events.size() == 0) begin
                    $display("%0t: key event %02h arrived with none expected",
                             $time, got.key_code);
                    error_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("key_code", want.key_code, got.key_code);
                    check_field("extended", BYTE_W'(want.extended), BYTE_W'(got.extended));
                    check_field("released", BYTE_W'(want.released), BYTE_W'(got.released));
                    for (int m = 0; m < MOD_COUNT; m++) begin
                        check_field(mod_names[m], BYTE_W'(want.mods[m]),
                                    BYTE_W'(got.mods[m]));
                    end
                end
            end
            if (sink_hold) begin
                event_ch.ready <= 1'b0;
            end else if (!recv_gaps_on) begin
                event_ch.ready <= 1'b1;
            end else if (recv_wait != 0) begin
                event_ch.ready <= 1'b0;
                recv_wait      <= recv_wait - 1;
            end else begin
                event_ch.ready <= 1'b1;
                recv_wait      <= draw_gap();
            end
        end
    end

    // Long receiver stall: hold ready low for a fixed stretch so the decoder
    // backs up and stalls its byte input.
    initial begin
        forever begin
            @(begin_sink_stall);
            sink_hold <= 1'b1;
            repeat (LONG_STALL_CYCLES) @(posedge i_clk);
            sink_hold <= 1'b0;
        end
    end

    // Key code for a well-formed sequence: often a modifier, never a prefix byte
    function automatic logic [BYTE_W-1:0] draw_key_code();
        logic [BYTE_W-1:0] code;
        if ($urandom_range(0, 99) < 45) begin
            case ($urandom_range(0, 3))
                0:       return CODE_ALT;
                1:       return CODE_SHIFT_L;
                2:       return CODE_CTRL;
                default: return CODE_SHIFT_R;
            endcase
        end
        do begin
            code = 8'($urandom_range(0, 255));
        end while (code == BYTE_RELEASE || code == BYTE_EXTENDED || code == BYTE_PAUSE);
        return code;
    endfunction

    // Queue random traffic until about target bytes are queued, pause
    // filler included.
    task automatic queue_random_traffic(input int unsigned target);
        int unsigned counted;
        int unsigned pick;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // make or break code, extended one time in three
                if ($urandom_range(0, 2) == 0) begin
                    pending_bytes.push_back(BYTE_EXTENDED);
                    counted++;
                end
                if (pick >= 35) begin
                    pending_bytes.push_back(BYTE_RELEASE);
                    counted++;
                end
                pending_bytes.push_back(draw_key_code());
                counted++;
            end else if (pick < 80) begin
                // full pause sequence with random filler
                pending_bytes.push_back(BYTE_PAUSE);
                repeat (PAUSE_LENGTH - 1) pending_bytes.push_back(8'($urandom_range(0, 255)));
                counted += PAUSE_LENGTH;
            end else begin
                // noise: stray prefixes and any byte at all
                case ($urandom_range(0, 9))
                    0:       pending_bytes.push_back(BYTE_RELEASE);
                    1:       pending_bytes.push_back(BYTE_EXTENDED);
                    2:       pending_bytes.push_back(BYTE_PAUSE);
                    default: pending_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
                counted++;
            end
        end
    endtask

    // Hold until every byte has transferred and every event has come back
    task automatic wait_until_drained();
        while (pending_bytes.size() != 0 || byte_ch.valid || expected_events.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Stimulus: reset, directed opening, then random phases with and without
    // idling, and one phase under a long receiver stall.
    initial begin
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        event_ch.ready  = 1'b0;
        clear_decoder_state();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (OPENING_BYTES[k]) pending_bytes.push_back(OPENING_BYTES[k]);
        wait_until_drained();

        queue_random_traffic(200);
        wait_until_drained();

        // back-to-back on both sides
        send_gaps_on <= 1'b0;
        recv_gaps_on <= 1'b0;
        queue_random_traffic(120);
        wait_until_drained();

        // sender keeps offering while the receiver holds off
        recv_gaps_on <= 1'b1;
        -> begin_sink_stall;
        queue_random_traffic(150);
        wait_until_drained();

        send_gaps_on <= 1'b1;
        queue_random_traffic(130);
        wait_until_drained();

        // let any stray event surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
